// ===== sv/serial_frame_deframer_crc16_assert.svh =====
// Assertion macros used by the deframer RTL (sfd_skid).
// Depends on a clk and an active-low rst_n in the including module.
`ifndef SERIAL_FRAME_DEFRAMER_CRC16_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_CRC16_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Check cons in the cycle after ante.
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== sv/sfd_pkg.sv =====
// Types, constants and the byte-wide CRC-16/CCITT-FALSE update for the deframer.
// No dependencies.
`default_nettype none

package sfd_pkg;

    localparam logic [7:0]  MAX_FRAME   = 8'd128;
    localparam logic [8:0]  FRAME_OVHD  = 9'd5;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  START_RESET = 8'hB2;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_CRC_BAD = 2'd1;
    localparam logic [1:0] VERDICT_TOO_LONG = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2,
        PH_CRC  = 2'd3
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [7:0] id;
        logic [7:0] length;
        logic [1:0] verdict;
    } res_t;

    function automatic logic [15:0] sfd_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/serial_frame_deframer_crc16.sv =====
// Top level of the framed serial receiver with CRC-16/CCITT-FALSE check.
// Depends on sfd_pkg, sfd_parser and sfd_skid.
//
//   channel      dir  tdata / tuser fields (low bit up)
//   s_axis       in   tdata: rx_byte[7:0]
//   m_axis       out  tdata: payload_byte, frame_id, payload_length, verdict; tuser: result_kind
//   start_byte   in   write enable plus 8-bit write data, no read-back
//
// One word is taken per cycle while s_axis_tready is high; a result is registered in the output or skid stage.
// The parser state and CRC update in the cycle a word is accepted.
// A one-word skid stage keeps s_axis_tready high through a single stalled result.
// s_axis_tready drops only while the skid stage holds a word.
// Reset clears the phase to hunting and the start byte to 0xB2.
`default_nettype none

module serial_frame_deframer_crc16
    import sfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start_byte_we,
    input  wire logic [7:0]  start_byte_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_id,
                                             // [23:16] payload_length, [25:24] verdict
    output logic [0:0]       m_axis_tuser    // [0] result_kind
);

    logic accept;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    sfd_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .start_byte_we    (start_byte_we),
        .start_byte_wdata (start_byte_wdata),
        .in_valid         (accept),
        .in_byte          (s_axis_tdata),
        .res_valid        (res_valid),
        .res              (res)
    );

    sfd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .ready     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.verdict, out_res.length, out_res.id, out_res.payload};
    assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

// ===== sv/sfd_parser.sv =====
// Frame parser: phase machine, running CRC and start byte register.
// Depends on sfd_pkg.
`default_nettype none

module sfd_parser
    import sfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start_byte_we,
    input  wire logic [7:0] start_byte_wdata,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    output logic            res_valid,
    output res_t            res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  start_byte_reg;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [7:0]  current_id_reg, current_id_next;
    logic [7:0]  declared_length_reg, declared_length_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  received_crc_high_reg, received_crc_high_next;
    logic [15:0] crc_step;
    logic [7:0]  index_inc;

    assign crc_step  = sfd_crc_byte(running_crc_reg, in_byte);
    assign index_inc = byte_index_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_HUNT;
            start_byte_reg        <= START_RESET;
            byte_index_reg        <= '0;
            current_id_reg        <= '0;
            declared_length_reg   <= '0;
            running_crc_reg       <= CRC_INIT;
            received_crc_high_reg <= '0;
        end
        else
        begin
            phase_reg             <= phase_next;
            byte_index_reg        <= byte_index_next;
            current_id_reg        <= current_id_next;
            declared_length_reg   <= declared_length_next;
            running_crc_reg       <= running_crc_next;
            received_crc_high_reg <= received_crc_high_next;
            if (start_byte_we)
            begin
                start_byte_reg <= start_byte_wdata;
            end
        end
    end

    always_comb
    begin
        phase_next             = phase_reg;
        byte_index_next        = byte_index_reg;
        current_id_next        = current_id_reg;
        declared_length_next   = declared_length_reg;
        running_crc_next       = running_crc_reg;
        received_crc_high_next = received_crc_high_reg;
        res_valid              = 1'b0;
        res.kind               = KIND_PAYLOAD;
        res.payload            = '0;
        res.id                 = current_id_reg;
        res.length             = declared_length_reg;
        res.verdict            = VERDICT_OK;
        if (in_valid)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (in_byte == start_byte_reg)
                    begin
                        phase_next       = PH_HEAD;
                        byte_index_next  = '0;
                        running_crc_next = CRC_INIT;
                    end
                end
                PH_HEAD:
                begin
                    running_crc_next = crc_step;
                    if (byte_index_reg == 8'd0)
                    begin
                        current_id_next = in_byte;
                        byte_index_next = 8'd1;
                    end
                    else
                    begin
                        declared_length_next = in_byte;
                        byte_index_next      = '0;
                        res.length           = in_byte;
                        if (({1'b0, in_byte} + FRAME_OVHD) > {1'b0, MAX_FRAME})
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_VERDICT;
                            res.verdict      = VERDICT_TOO_LONG;
                            phase_next       = PH_HUNT;
                            running_crc_next = CRC_INIT;
                        end
                        else
                        begin
                            phase_next = (in_byte == 8'd0) ? PH_CRC : PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    running_crc_next = crc_step;
                    byte_index_next  = index_inc;
                    res_valid        = 1'b1;
                    res.payload      = in_byte;
                    if (index_inc >= declared_length_reg)
                    begin
                        phase_next      = PH_CRC;
                        byte_index_next = '0;
                    end
                end
                PH_CRC:
                begin
                    if (byte_index_reg == 8'd0)
                    begin
                        received_crc_high_next = in_byte;
                        byte_index_next        = 8'd1;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_VERDICT;
                        res.verdict      = ({received_crc_high_reg, in_byte} == running_crc_reg)
                                           ? VERDICT_OK : VERDICT_CRC_BAD;
                        phase_next       = PH_HUNT;
                        byte_index_next  = '0;
                        running_crc_next = CRC_INIT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/sfd_skid.sv =====
// Output register with one skid stage between the parser and the result stream.
// Depends on sfd_pkg and serial_frame_deframer_crc16_assert.svh.
`default_nettype none

module sfd_skid
    import sfd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_res,
    output logic      ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    `include "serial_frame_deframer_crc16_assert.svh"

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_res_reg, out_res_next;
    res_t skid_res_reg, skid_res_next;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_res_next    = skid_valid_reg ? skid_res_reg : push_res;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    `SFD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `SFD_ASSERT_NEXT(a_push_lands, push && out_free, out_valid_reg && !skid_valid_reg)
    `SFD_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !out_ready,
                     skid_valid_reg && $stable(skid_res_reg))

endmodule

`default_nettype wire
